// ----- src/mfd_pkg.sv -----
package mfd_pkg;

   localparam logic [7:0] HDR0      = 8'hF1;
   localparam logic [7:0] HDR1      = 8'hDD;
   localparam logic [7:0] MSG_KIND  = 8'h02;
   localparam logic [7:0] MIN_LEN   = 8'h04;

   // results per transaction at most, and output queue depth
   localparam int unsigned MAX_RES   = 3;
   localparam int unsigned QDEPTH    = 4;
   localparam int unsigned QPTR_W    = $clog2(QDEPTH);
   localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [1:0] CSR_CONN_TYPE = 2'd0;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN     = 3'd1,
      PH_ADDR0   = 3'd2,
      PH_ADDR1   = 3'd3,
      PH_SKIP0   = 3'd4,
      PH_SKIP1   = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   // results produced by one input byte
   typedef struct packed {
      logic [1:0]                 count;
      logic [MAX_RES-1:0][7:0]    data;
      logic [MAX_RES-1:0]         last;
   } res_type;

endpackage

// ----- src/mfd_parser.sv -----
module mfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [7:0]       conn_type,
   output mfd_pkg::res_type res,
   output mfd_pkg::phase_type phase
);

   mfd_pkg::phase_type phase_ff, phase_in;
   logic       saw_ff, saw_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] left_dec;

   assign left_dec = left_ff - 8'd1;
   assign phase    = phase_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      saw_in   = saw_ff;
      left_in  = left_ff;
      unique case (phase_ff)
         mfd_pkg::PH_LEN: begin
            saw_in = 1'b0;
            if (rx_byte < mfd_pkg::MIN_LEN) begin
               phase_in = mfd_pkg::PH_HUNT;
            end else begin
               left_in  = rx_byte - mfd_pkg::MIN_LEN;
               phase_in = mfd_pkg::PH_ADDR0;
            end
         end
         mfd_pkg::PH_ADDR0: phase_in = mfd_pkg::PH_ADDR1;
         mfd_pkg::PH_ADDR1: phase_in = mfd_pkg::PH_SKIP0;
         mfd_pkg::PH_SKIP0: phase_in = mfd_pkg::PH_SKIP1;
         mfd_pkg::PH_SKIP1: begin
            phase_in = (left_ff == 8'd0) ? mfd_pkg::PH_HUNT : mfd_pkg::PH_PAYLOAD;
         end
         mfd_pkg::PH_PAYLOAD: begin
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = mfd_pkg::PH_HUNT;
            end
         end
         default: begin
            if (saw_ff && rx_byte == mfd_pkg::HDR1) begin
               saw_in   = 1'b0;
               phase_in = mfd_pkg::PH_LEN;
            end else begin
               saw_in   = (rx_byte == mfd_pkg::HDR0);
               phase_in = mfd_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // results for the current byte
   always_comb begin
      res = '0;
      unique case (phase_ff)
         mfd_pkg::PH_LEN: begin
            if (rx_byte >= mfd_pkg::MIN_LEN) begin
               res.count   = 2'd3;
               res.data[0] = conn_type;
               res.data[1] = mfd_pkg::MSG_KIND;
               res.data[2] = rx_byte - mfd_pkg::MIN_LEN;
            end
         end
         mfd_pkg::PH_ADDR0: begin
            res.count   = 2'd1;
            res.data[0] = rx_byte;
         end
         mfd_pkg::PH_ADDR1: begin
            res.count   = 2'd1;
            res.data[0] = rx_byte;
            res.last[0] = (left_ff == 8'd0);
         end
         mfd_pkg::PH_PAYLOAD: begin
            res.count   = 2'd1;
            res.data[0] = rx_byte;
            res.last[0] = (left_dec == 8'd0);
         end
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mfd_pkg::PH_HUNT;
         saw_ff   <= 1'b0;
         left_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         saw_ff   <= saw_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ----- src/mesh_frame_deframer_top.sv -----
// A byte accepted on req_ is parsed from the input register into the output queue.
// Throughput: one byte per cycle while the queue has room; a length byte yields
//   three results, drained at most one per cycle through a 4-entry output queue,
//   so req_ready drops while it would hold more than one after this cycle's read.
// Reset: synchronous, active high; parser back to header hunt, queue emptied,
//   connection type register cleared to zero.
module mesh_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- configuration ----------------
   logic [7:0] conn_type_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // one register; word index is paddr[2]
   always_ff @(posedge clock) begin
      if (reset) begin
         conn_type_ff <= 8'd0;
      end else if (csr_wr && {1'b0, csr_paddr[2]} == mfd_pkg::CSR_CONN_TYPE) begin
         conn_type_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if ({1'b0, csr_paddr[2]} == mfd_pkg::CSR_CONN_TYPE) begin
         csr_prdata = {24'd0, conn_type_ff};
      end
   end

   // ---------------- input register ----------------
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       adv;       // input register byte is parsed this cycle
   logic       pop;
   logic [mfd_pkg::QCNT_W-1:0] cnt_ff, cnt_in, cnt_eff;

   assign pop     = rsp_valid & rsp_ready;
   assign cnt_eff = cnt_ff - mfd_pkg::QCNT_W'(pop);
   // room for a worst-case three results after this cycle's read
   assign adv       = in_vld_ff &&
                      (cnt_eff <= mfd_pkg::QCNT_W'(mfd_pkg::QDEPTH - mfd_pkg::MAX_RES));
   assign req_ready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // ---------------- parser ----------------
   mfd_pkg::res_type   res;
   mfd_pkg::phase_type phase;

   mfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (adv),
      .rx_byte   (in_byte_ff),
      .conn_type (conn_type_ff),
      .res       (res),
      .phase     (phase)
   );

   // ---------------- output queue ----------------
   // entries hold {last, byte}; up to three written per cycle, one read
   logic [mfd_pkg::QDEPTH-1:0][8:0]   q_ff;
   logic [mfd_pkg::QPTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                        push_n;

   assign push_n = adv ? res.count : 2'd0;
   assign cnt_in = cnt_eff + mfd_pkg::QCNT_W'(push_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + mfd_pkg::QPTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + mfd_pkg::QPTR_W'(pop);
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < mfd_pkg::MAX_RES; k++) begin
         if (k < int'(push_n)) begin
            q_ff[wr_ptr_ff + mfd_pkg::QPTR_W'(k)] <= {res.last[k], res.data[k]};
         end
      end
   end

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_out_byte = q_ff[rd_ptr_ff][7:0];
   assign rsp_out_last = q_ff[rd_ptr_ff][8];

   // ---------------- checks ----------------
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= mfd_pkg::QCNT_W'(mfd_pkg::QDEPTH))
      else $error("output queue overflow");

   a_q_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with mismatched pointers");

   a_hdr_burst: assert property (@(posedge clock) disable iff (reset)
      adv && res.count == 2'd3 |=> cnt_ff >= mfd_pkg::QCNT_W'(mfd_pkg::MAX_RES))
      else $error("length byte results not all queued");

   a_three_from_len: assert property (@(posedge clock) disable iff (reset)
      res.count == 2'd3 |-> phase == mfd_pkg::PH_LEN)
      else $error("three results outside length phase");

endmodule

// ----- dv/mesh_frame_deframer_top_test.sv -----
module mesh_frame_deframer_top_test;

   // one byte of a rewritten message as it should leave the block
   typedef struct {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bytes waiting to be offered on req_
   logic [7:0]  rx_stream[$];
   // message bytes predicted but not yet seen on rsp_
   msg_byte_type msg_bytes_due[$];

   // deframer state as the testbench tracks it
   logic [7:0]  conn_type_copy = 8'h00;
   mfd_pkg::phase_type frm_phase = mfd_pkg::PH_HUNT;
   logic        saw_hdr0 = 1'b0;
   logic [7:0]  payload_left = 8'h00;

   int          fail_count = 0;
   bit          idle_on = 1'b0;     // random idle bursts enabled on both sides
   bit          hold_arm = 1'b0;    // request for one long receiver hold-off
   int          send_gap = 0;

   mesh_frame_deframer_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop in case the handshakes hang
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   task automatic log_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", what);
      end
   endtask

   task automatic push_msg_byte(input logic [7:0] data, input logic last);
      msg_byte_type m;
      m.data = data;
      m.last = last;
      msg_bytes_due.push_back(m);
   endtask

   // Tracks the deframer for one accepted byte and queues the message bytes
   // it should produce.
   task automatic deframe_byte(input logic [7:0] b);
      case (frm_phase)
         mfd_pkg::PH_LEN: begin
            if (b < mfd_pkg::MIN_LEN) begin
               // short length: frame dropped, back to the hunt
               frm_phase = mfd_pkg::PH_HUNT;
            end else begin
               payload_left = b - mfd_pkg::MIN_LEN;
               push_msg_byte(conn_type_copy, 1'b0);
               push_msg_byte(mfd_pkg::MSG_KIND, 1'b0);
               push_msg_byte(b - mfd_pkg::MIN_LEN, 1'b0);
               frm_phase = mfd_pkg::PH_ADDR0;
            end
            saw_hdr0 = 1'b0;
         end
         mfd_pkg::PH_ADDR0: begin
            push_msg_byte(b, 1'b0);
            frm_phase = mfd_pkg::PH_ADDR1;
         end
         mfd_pkg::PH_ADDR1: begin
            // empty payload closes the message on the second address byte
            push_msg_byte(b, payload_left == 8'h00);
            frm_phase = mfd_pkg::PH_SKIP0;
         end
         mfd_pkg::PH_SKIP0: begin
            frm_phase = mfd_pkg::PH_SKIP1;
         end
         mfd_pkg::PH_SKIP1: begin
            frm_phase = (payload_left == 8'h00) ? mfd_pkg::PH_HUNT : mfd_pkg::PH_PAYLOAD;
         end
         mfd_pkg::PH_PAYLOAD: begin
            payload_left = payload_left - 8'h01;
            push_msg_byte(b, payload_left == 8'h00);
            if (payload_left == 8'h00) begin
               frm_phase = mfd_pkg::PH_HUNT;
            end
         end
         default: begin
            // a run of 0xF1 still counts: only the latest one matters
            if (saw_hdr0 && b == mfd_pkg::HDR1) begin
               saw_hdr0 = 1'b0;
               frm_phase = mfd_pkg::PH_LEN;
            end else begin
               saw_hdr0 = (b == mfd_pkg::HDR0);
               frm_phase = mfd_pkg::PH_HUNT;
            end
         end
      endcase
   endtask

   // Sender: offers bytes from rx_stream, with random idle bursts between
   // transactions. Prediction happens at the edge that accepts the byte.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
            end
         end
      end
   end

   // Receiver ready: random stalls, plus one long hold-off so the output
   // queue fills and req_ready drops while bytes are still on offer.
   int  hold_left = 0;
   int  ready_gap = 0;
   bit  hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         ready_gap = 0;
      end else begin
         if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: every result transaction against the oldest predicted byte.
   // Prediction at the accepting edge keeps the push ahead of the pop.
   always @(posedge clock) begin
      msg_byte_type m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (msg_bytes_due.size() == 0) begin
            log_failure($sformatf("unexpected result: byte %02h last %0b",
                                  rsp_out_byte, rsp_out_last));
         end else begin
            m = msg_bytes_due.pop_front();
            if (rsp_out_byte !== m.data || rsp_out_last !== m.last) begin
               log_failure($sformatf(
                  "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                  m.data, m.last, rsp_out_byte, rsp_out_last));
            end
         end
      end
   end

   // APB write of the connection type register, then a read back of it.
   task automatic program_conn_type(input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * mfd_pkg::CSR_CONN_TYPE);
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      conn_type_copy = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== value) begin
         log_failure($sformatf("conn type read: expected %02h, got %02h",
                               value, csr_prdata[7:0]));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Register writes only once the block has gone quiet. Skip bytes give no
   // result, so a further wait covers any still inside the pipeline.
   task automatic wait_drained();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || msg_bytes_due.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 3);
      if (r < 16) return 4;
      if (r < 20) return $urandom_range(40, 80);
      return $urandom_range(5, 16);
   endfunction

   // Queues one frame, possibly with leading junk, a repeated 0xF1, or cut
   // short so the next frame's header lands inside it.
   task automatic queue_frame(input int len, input bit may_break, output int n);
      logic [7:0] frame[$];
      int         r;
      int         body;
      frame = {};
      r = $urandom_range(0, 99);
      if (r < 20) begin
         frame = {8'h4F, 8'h4B, 8'h0D, 8'h0A};   // "OK\r\n" acknowledgement
      end else if (r < 40) begin
         repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < 15) begin
         frame.push_back(mfd_pkg::HDR0);
      end
      frame.push_back(mfd_pkg::HDR0);
      frame.push_back(mfd_pkg::HDR1);
      frame.push_back(8'(len));
      // address, skip and payload bytes together add up to L
      body = (len < 4) ? 0 : len;
      repeat (body) frame.push_back(8'($urandom));
      if (may_break && body > 0 && $urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, body)) void'(frame.pop_back());
      end
      n = frame.size();
      foreach (frame[i]) rx_stream.push_back(frame[i]);
   endtask

   task automatic queue_random(input int budget);
      int total;
      int n;
      total = 0;
      while (total < budget) begin
         queue_frame(pick_len(), 1'b1, n);
         total += n;
      end
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: acknowledgement text, 0xF1 run before 0xDD, empty payload
      // with extreme address bytes, short length, 0xF1 x 0xDD that is no
      // header, and header bytes sitting inside a frame's payload.
      program_conn_type(8'h00);
      rx_stream = {8'h4F, 8'h4B,
                   mfd_pkg::HDR0, mfd_pkg::HDR0, mfd_pkg::HDR1, 8'd4,
                   8'h00, 8'hFF, 8'h5A, 8'hA5,
                   mfd_pkg::HDR0, mfd_pkg::HDR1, 8'd3,
                   mfd_pkg::HDR0, 8'h00, mfd_pkg::HDR1,
                   mfd_pkg::HDR0, mfd_pkg::HDR1, 8'd5, 8'hFF, 8'h00,
                   mfd_pkg::HDR0, mfd_pkg::HDR1, mfd_pkg::HDR0};
      wait_drained();

      // Longest frame and a zero length first, then random frames. The
      // receiver stalls for a long stretch while the sender keeps going.
      program_conn_type(8'hFF);
      idle_on = 1'b1;
      queue_frame(255, 1'b0, n);
      queue_frame(0, 1'b0, n);
      queue_random(20);
      hold_arm = 1'b1;
      wait_drained();

      program_conn_type(8'($urandom));
      queue_random(15);
      wait_drained();

      // final stretch runs with no idling on either side
      program_conn_type(8'h80);
      idle_on = 1'b0;
      queue_random(15);

      do @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || msg_bytes_due.size() != 0);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
